@@ src/slmd_pkg.sv @@
// Shared types and constants for the strict 3x3 local minimum detector.
// Used by slmd_window and strict_local_minimum_detector_3x3_core.
`timescale 1ns / 1ps
`default_nettype none

package slmd_pkg;

	// configuration register map
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 13;
	localparam int ROWS_REG_BITS  = 13;
	localparam int COLS_REG_BITS  = 7;

	localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_COLS = 1'b1;

	// stream field widths
	localparam int SAMPLE_IN_BITS = 16;
	localparam int ROW_OUT_BITS   = 12;
	localparam int COL_OUT_BITS   = 6;
	localparam int VALUE_OUT_BITS = 16;
	localparam int COUNT_BITS     = 18;
	localparam int TDATA_OUT_BITS = 56;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SHIFT  = 6'b000010,
		S_EMIT_A = 6'b000100,
		S_EMIT_B = 6'b001000,
		S_READ   = 6'b010000,
		S_SUM    = 6'b100000
	} state_t;

	// window control from the sequencer
	typedef struct packed {
		logic shift;
		logic up_ok;
		logic down_ok;
		logic left_a;
	} win_ctl_t;

	// decisions for the center column and the right column
	typedef struct packed {
		logic min_a;
		logic min_b;
	} win_flags_t;

endpackage

`default_nettype wire

@@ src/strict_local_minimum_detector_3x3_core.sv @@
// Strict 3x3 local minimum detector: sequencer, line memory and report register.
// Depends on slmd_pkg and slmd_window.
//
// Usage:
//   s_* channel takes one sample per transfer in raster order. m_* channel gives
//   one report per transfer: a minimum (tuser = 0) with row, column, value and
//   running count, or the end-of-frame summary (tuser = 1) with the count.
//   tlast marks the final report caused by one input sample.
//   cfg_we/cfg_index/cfg_data set rows (index 0) and columns (index 1); a write
//   restarts the frame. Write only while the block is idle.
// Timing:
//   Each sample passes through accept, memory read/window shift and two report
//   slots before the next is accepted; a report is shown by the output register
//   in the cycle after its slot. A frame's last sample adds a sweep of the last
//   row, column by column, then the summary. The rate is set by the sequencer
//   stepping through the single line memory read and the two report slots.
// Reset and stall:
//   Reset clears position, count and sizes (2 x 2 frame); the line memory is
//   not cleared and needs no sweep. A stalled receiver holds the report and
//   the sequencer waits in its report slot.
`timescale 1ns / 1ps
`default_nettype none

module strict_local_minimum_detector_3x3_core import slmd_pkg::*; #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [SAMPLE_IN_BITS-1:0] s_tdata,  // [15:0] sample
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [TDATA_OUT_BITS-1:0] m_tdata,  // min_row, min_col, min_value, minima_count
	output logic                      m_tuser,  // is_summary
	output logic                      m_tlast,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COLS_P2   = 1 << CW;
	localparam int MEM_DEPTH = 3 * COLS_P2;
	localparam int AW        = CW + 2;

	state_t state_q;

	logic [RW-1:0]          row_q, last_row_q;
	logic [CW-1:0]          col_q, last_col_q, j_q;
	logic                   flush_q, eof_q;
	logic [COUNT_BITS-1:0]  count_q, count_inc;
	logic [1:0]             cur_bank_q, p1_bank_q, p2_bank_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	// line memory: three row banks, one write and two read ports
	logic [SAMPLE_BITS-1:0] mem_q [MEM_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
	logic [AW-1:0]          wr_addr, rd_addr_a, rd_addr_b;
	logic [CW-1:0]          rd_col;
	logic                   s_fire;

	win_ctl_t               win_ctl;
	win_flags_t             flags;
	logic [SAMPLE_BITS-1:0] val_a, val_b;

	logic [CW-1:0]          k_col;
	logic                   chk_a, chk_b, slot_free;
	logic                   load_a, load_b, load_sum, a_done, b_done;
	logic [RW-1:0]          rep_row, rows_m1;
	logic [CW-1:0]          cols_m1;

	// report register
	logic                      m_tvalid_q;
	logic                      out_sum_q, out_last_q;
	logic [ROW_OUT_BITS-1:0]   out_row_q;
	logic [COL_OUT_BITS-1:0]   out_col_q;
	logic [VALUE_OUT_BITS-1:0] out_val_q;
	logic [COUNT_BITS-1:0]     out_cnt_q;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	assign rd_col    = (state_q == S_IDLE) ? col_q : j_q;
	assign wr_addr   = {cur_bank_q, col_q};
	assign rd_addr_a = {flush_q ? p1_bank_q : p2_bank_q, rd_col};
	assign rd_addr_b = {flush_q ? cur_bank_q : p1_bank_q, rd_col};

	always_ff @(posedge clk) begin
		if (s_fire) begin
			mem_q[wr_addr] <= SAMPLE_BITS'(s_tdata);
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	// during the last-row sweep the window rows are (last-1, last, unused)
	assign k_col = flush_q ? j_q : col_q;
	assign chk_a = flush_q ? (j_q != '0) : ((row_q != '0) && (col_q != '0));
	assign chk_b = (k_col == last_col_q) && (flush_q || (row_q != '0));

	assign win_ctl.shift   = (state_q == S_SHIFT);
	assign win_ctl.up_ok   = flush_q || (row_q > RW'(1));
	assign win_ctl.down_ok = !flush_q;
	assign win_ctl.left_a  = (k_col > CW'(1));

	slmd_window #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_window (
		.clk     (clk),
		.ctl     (win_ctl),
		.col_top (rd_a_q),
		.col_mid (rd_b_q),
		.col_bot (sample_q),
		.flags   (flags),
		.val_a   (val_a),
		.val_b   (val_b)
	);

	assign slot_free = !m_tvalid_q || m_tready;
	assign count_inc = (count_q == COUNT_TOP) ? count_q : count_q + 1'b1;
	assign rep_row   = flush_q ? row_q : row_q - 1'b1;

	assign load_a   = (state_q == S_EMIT_A) && chk_a && flags.min_a && slot_free;
	assign load_b   = (state_q == S_EMIT_B) && chk_b && flags.min_b && slot_free;
	assign load_sum = (state_q == S_SUM) && slot_free;
	assign a_done   = !(chk_a && flags.min_a) || slot_free;
	assign b_done   = !(chk_b && flags.min_b) || slot_free;

	// clamp register writes into the supported frame size
	always_comb begin
		if (cfg_data[ROWS_REG_BITS-1:0] < ROWS_REG_BITS'(2)) begin
			rows_m1 = RW'(1);
		end else if (32'(cfg_data[ROWS_REG_BITS-1:0]) > 32'(MAX_ROWS)) begin
			rows_m1 = RW'(MAX_ROWS - 1);
		end else begin
			rows_m1 = RW'(cfg_data[ROWS_REG_BITS-1:0] - ROWS_REG_BITS'(1));
		end
		if (cfg_data[COLS_REG_BITS-1:0] < COLS_REG_BITS'(2)) begin
			cols_m1 = CW'(1);
		end else if (32'(cfg_data[COLS_REG_BITS-1:0]) > 32'(MAX_COLS)) begin
			cols_m1 = CW'(MAX_COLS - 1);
		end else begin
			cols_m1 = CW'(cfg_data[COLS_REG_BITS-1:0] - COLS_REG_BITS'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			j_q        <= '0;
			flush_q    <= 1'b0;
			eof_q      <= 1'b0;
			count_q    <= '0;
			cur_bank_q <= 2'd0;
			p1_bank_q  <= 2'd1;
			p2_bank_q  <= 2'd2;
			last_row_q <= RW'(1);
			last_col_q <= CW'(1);
		end else begin
			if (load_a || load_b || load_sum) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						eof_q   <= (row_q == last_row_q) && (col_q == last_col_q);
						flush_q <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					state_q <= S_EMIT_A;
				end
				S_EMIT_A: begin
					if (load_a) begin
						count_q <= count_inc;
					end
					if (a_done) begin
						state_q <= S_EMIT_B;
					end
				end
				S_EMIT_B: begin
					if (load_b) begin
						count_q <= count_inc;
					end
					if (b_done) begin
						if (flush_q) begin
							if (j_q == last_col_q) begin
								state_q <= S_SUM;
							end else begin
								j_q     <= j_q + 1'b1;
								state_q <= S_READ;
							end
						end else if (eof_q) begin
							// sweep the last row from column zero
							flush_q <= 1'b1;
							j_q     <= '0;
							state_q <= S_READ;
						end else begin
							if (col_q == last_col_q) begin
								col_q      <= '0;
								row_q      <= row_q + 1'b1;
								cur_bank_q <= p2_bank_q;
								p1_bank_q  <= cur_bank_q;
								p2_bank_q  <= p1_bank_q;
							end else begin
								col_q <= col_q + 1'b1;
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_READ: begin
					state_q <= S_SHIFT;
				end
				S_SUM: begin
					if (slot_free) begin
						row_q   <= '0;
						col_q   <= '0;
						count_q <= '0;
						flush_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_ROWS: last_row_q <= rows_m1;
					REG_NUM_COLS: last_col_q <= cols_m1;
					default: ;
				endcase
				row_q   <= '0;
				col_q   <= '0;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			sample_q <= SAMPLE_BITS'(s_tdata);
		end
		if (load_a) begin
			out_sum_q  <= 1'b0;
			out_row_q  <= ROW_OUT_BITS'(rep_row);
			out_col_q  <= COL_OUT_BITS'(k_col - 1'b1);
			out_val_q  <= VALUE_OUT_BITS'(val_a);
			out_cnt_q  <= count_inc;
			out_last_q <= !eof_q && !(chk_b && flags.min_b);
		end else if (load_b) begin
			out_sum_q  <= 1'b0;
			out_row_q  <= ROW_OUT_BITS'(rep_row);
			out_col_q  <= COL_OUT_BITS'(k_col);
			out_val_q  <= VALUE_OUT_BITS'(val_b);
			out_cnt_q  <= count_inc;
			out_last_q <= !eof_q;
		end else if (load_sum) begin
			out_sum_q  <= 1'b1;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_val_q  <= '0;
			out_cnt_q  <= count_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_sum_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_cnt_q, out_val_q, out_col_q, out_row_q};

`ifndef ASSERT_OFF
	a_banks_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |-> ((cur_bank_q != p1_bank_q) && (cur_bank_q != p2_bank_q) &&
			(p1_bank_q != p2_bank_q)))
		else $error("line memory banks overlap at sample transfer");

	a_sum_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (flush_q && (j_q == last_col_q)))
		else $error("summary reached before last row sweep finished");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_col_q) && (row_q <= last_row_q))
		else $error("frame position outside configured size");

	a_sum_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("summary report without tlast");
`endif

endmodule

`default_nettype wire

@@ src/slmd_window.sv @@
// 3x3 sample window with the strict minimum compare for two candidate centers.
// Depends on slmd_pkg for the control and flag structs.
`timescale 1ns / 1ps
`default_nettype none

module slmd_window import slmd_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  win_ctl_t               ctl,
	input  logic [SAMPLE_BITS-1:0] col_top,
	input  logic [SAMPLE_BITS-1:0] col_mid,
	input  logic [SAMPLE_BITS-1:0] col_bot,
	output win_flags_t             flags,
	output logic [SAMPLE_BITS-1:0] val_a,
	output logic [SAMPLE_BITS-1:0] val_b
);

	// [row][col]: row 0 above the center row, col 2 the newest column
	logic [SAMPLE_BITS-1:0] win_q [3][3];
	logic [SAMPLE_BITS-1:0] new_col [3];

	assign new_col[0] = col_top;
	assign new_col[1] = col_mid;
	assign new_col[2] = col_bot;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
				win_q[i][2] <= new_col[i];
			end
		end
	end

	assign val_a = win_q[1][1];
	assign val_b = win_q[1][2];

	always_comb begin
		logic up, dn, lf;
		up = ctl.up_ok;
		dn = ctl.down_ok;
		lf = ctl.left_a;
		// center in the middle column, right neighbor always present
		flags.min_a = (!(up && lf) || (win_q[0][0] > val_a)) &&
			(!up || (win_q[0][1] > val_a)) &&
			(!up || (win_q[0][2] > val_a)) &&
			(!lf || (win_q[1][0] > val_a)) &&
			(win_q[1][2] > val_a) &&
			(!(dn && lf) || (win_q[2][0] > val_a)) &&
			(!dn || (win_q[2][1] > val_a)) &&
			(!dn || (win_q[2][2] > val_a));
		// center in the last column, no right neighbor
		flags.min_b = (!up || (win_q[0][1] > val_b)) &&
			(!up || (win_q[0][2] > val_b)) &&
			(win_q[1][1] > val_b) &&
			(!dn || (win_q[2][1] > val_b)) &&
			(!dn || (win_q[2][2] > val_b));
	end

endmodule

`default_nettype wire

@@ tb/sv/strict_local_minimum_detector_3x3_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for strict_local_minimum_detector_3x3_core: streams matrices
// of several sizes and predicts every minimum report and frame summary.
// Depends on slmd_pkg and the core RTL only.

module strict_local_minimum_detector_3x3_core_tb;
	import slmd_pkg::*;

	localparam int LINE_DEPTH     = 64;
	localparam int ROW_LIMIT      = 4096;
	localparam int SETTLE_CYCLES  = 24;
	localparam int HOLD_CYCLES    = 600;
	localparam int QUIET_LIMIT    = 3000;
	localparam int IDLE_PERCENT   = 18;
	localparam int PRINT_LIMIT    = 100;
	localparam int RANDOM_FRAMES  = 4;
	localparam int STEADY_SAMPLES = 48;

	// m_tdata layout, lowest bit up: min_row, min_col, min_value, minima_count
	localparam int COL_LSB   = ROW_OUT_BITS;
	localparam int VALUE_LSB = COL_LSB + COL_OUT_BITS;
	localparam int COUNT_LSB = VALUE_LSB + VALUE_OUT_BITS;

	typedef struct packed {
		logic                      summary;
		logic [ROW_OUT_BITS-1:0]   row;
		logic [COL_OUT_BITS-1:0]   col;
		logic [VALUE_OUT_BITS-1:0] value;
		logic [COUNT_BITS-1:0]     count;
		logic                      last;
	} report_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [SAMPLE_IN_BITS-1:0] s_tdata   = '0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [TDATA_OUT_BITS-1:0] m_tdata;
	logic                      m_tuser;
	logic                      m_tlast;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_NUM_ROWS;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// predictor state
	logic [ROWS_REG_BITS-1:0]  rows_setting = 13'd2;
	logic [COLS_REG_BITS-1:0]  cols_setting = 7'd2;
	logic [SAMPLE_IN_BITS-1:0] recent_rows [3][LINE_DEPTH];
	int                        next_row     = 0;
	int                        next_col     = 0;
	logic [COUNT_BITS-1:0]     minima_found = '0;
	report_t                   pending_reports [$];

	bit steady_flow    = 1'b0;
	int stall_requests = 0;
	int stall_served   = 0;
	int hold_left      = 0;
	int mismatches     = 0;
	int quiet_cycles   = 0;

	strict_local_minimum_detector_3x3_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int frame_rows();
		if (rows_setting < 2) return 2;
		if (rows_setting > ROW_LIMIT) return ROW_LIMIT;
		return int'(rows_setting);
	endfunction

	function automatic int frame_cols();
		if (cols_setting < 2) return 2;
		if (cols_setting > LINE_DEPTH) return LINE_DEPTH;
		return int'(cols_setting);
	endfunction

	// strictly below every neighbor that lies inside the frame
	function automatic bit is_strict_min(input int x, input int y, input int nr, input int nc);
		logic [SAMPLE_IN_BITS-1:0] centre;
		int dx;
		int dy;
		centre = recent_rows[x % 3][y];
		for (dx = -1; dx <= 1; dx++) begin
			for (dy = -1; dy <= 1; dy++) begin
				if ((dx != 0 || dy != 0) && x + dx >= 0 && x + dx < nr &&
				    y + dy >= 0 && y + dy < nc) begin
					if (recent_rows[(x + dx) % 3][y + dy] <= centre) return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	task automatic restart_frame();
		next_row = 0;
		next_col = 0;
		minima_found = '0;
	endtask

	task automatic predict_minima(input logic [SAMPLE_IN_BITS-1:0] sample);
		report_t batch [LINE_DEPTH + 3];
		int cand_row [LINE_DEPTH + 2];
		int cand_col [LINE_DEPTH + 2];
		int ncand;
		int n;
		int nr;
		int nc;
		int r;
		int c;
		int i;
		bit closing;
		ncand = 0;
		n = 0;
		nr = frame_rows();
		nc = frame_cols();
		r = next_row;
		c = next_col;
		recent_rows[r % 3][c] = sample;
		// an element is decided once the sample below-right of it arrives, or below it in the last column
		if (r >= 1 && c >= 1) begin
			cand_row[ncand] = r - 1;
			cand_col[ncand] = c - 1;
			ncand++;
		end
		if (r >= 1 && c == nc - 1) begin
			cand_row[ncand] = r - 1;
			cand_col[ncand] = c;
			ncand++;
		end
		closing = (r == nr - 1 && c == nc - 1);
		if (closing) begin
			for (i = 0; i < nc; i++) begin
				cand_row[ncand] = r;
				cand_col[ncand] = i;
				ncand++;
			end
		end
		for (i = 0; i < ncand; i++) begin
			if (is_strict_min(cand_row[i], cand_col[i], nr, nc)) begin
				if (minima_found != COUNT_TOP) minima_found++;
				batch[n].summary = 1'b0;
				batch[n].row = ROW_OUT_BITS'(cand_row[i]);
				batch[n].col = COL_OUT_BITS'(cand_col[i]);
				batch[n].value = recent_rows[cand_row[i] % 3][cand_col[i]];
				batch[n].count = minima_found;
				batch[n].last = 1'b0;
				n++;
			end
		end
		if (closing) begin
			batch[n] = '0;
			batch[n].summary = 1'b1;
			batch[n].count = minima_found;
			n++;
			restart_frame();
		end else if (c == nc - 1) begin
			next_col = 0;
			next_row = r + 1;
		end else begin
			next_col = c + 1;
		end
		if (n > 0) batch[n - 1].last = 1'b1;
		for (i = 0; i < n; i++) pending_reports.push_back(batch[i]);
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_report();
		report_t want;
		if (pending_reports.size() == 0) begin
			report_mismatch("report with none pending", m_tdata, 0);
			return;
		end
		want = pending_reports.pop_front();
		if (m_tuser !== want.summary) report_mismatch("is_summary", m_tuser, want.summary);
		if (m_tdata[ROW_OUT_BITS-1:0] !== want.row)
			report_mismatch("min_row", m_tdata[ROW_OUT_BITS-1:0], want.row);
		if (m_tdata[COL_LSB +: COL_OUT_BITS] !== want.col)
			report_mismatch("min_col", m_tdata[COL_LSB +: COL_OUT_BITS], want.col);
		if (m_tdata[VALUE_LSB +: VALUE_OUT_BITS] !== want.value)
			report_mismatch("min_value", m_tdata[VALUE_LSB +: VALUE_OUT_BITS], want.value);
		if (m_tdata[COUNT_LSB +: COUNT_BITS] !== want.count)
			report_mismatch("minima_count", m_tdata[COUNT_LSB +: COUNT_BITS], want.count);
		if (m_tlast !== want.last) report_mismatch("last_of_run", m_tlast, want.last);
	endtask

	// receiver: check each transfer, then pick tready for the next cycle
	always @(posedge clk) begin
		if (m_tvalid && m_tready) check_report();
		if (stall_served != stall_requests) begin
			stall_served = stall_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (steady_flow) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("strict_local_minimum_detector_3x3_core regression: fail");
				$finish;
			end
		end
	end

	task automatic wait_until_idle();
		while (pending_reports.size() != 0) @(posedge clk);
		// a sample that reports nothing may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		wait_until_idle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_NUM_ROWS) rows_setting = data[ROWS_REG_BITS-1:0];
		else cols_setting = data[COLS_REG_BITS-1:0];
		restart_frame();
	endtask

	task automatic send_sample(input logic [SAMPLE_IN_BITS-1:0] sample);
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= sample;
		do @(posedge clk); while (!s_tready);
		predict_minima(sample);
	endtask

	// mix of tight ranges (ties, many minima) and the full range
	function automatic logic [SAMPLE_IN_BITS-1:0] random_sample();
		case ($urandom_range(0, 3))
			0: return SAMPLE_IN_BITS'($urandom_range(0, 3));
			1: return SAMPLE_IN_BITS'($urandom);
			2: return $urandom_range(0, 1) ? '1 : '0;
			default: return SAMPLE_IN_BITS'($urandom_range(100, 108));
		endcase
	endfunction

	task automatic send_random_run(input int count);
		int i;
		for (i = 0; i < count; i++) send_sample(random_sample());
		s_tvalid <= 1'b0;
	endtask

	// 2 x 2 frame straight out of reset, extremes of the sample range
	task automatic test_default_frame();
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		s_tvalid <= 1'b0;
	endtask

	// sizes below two clamp to two; equal neighbors kill a minimum
	task automatic test_register_clamp();
		write_register(REG_NUM_ROWS, 13'd0);
		write_register(REG_NUM_COLS, 13'd1);
		send_sample(16'd7);
		send_sample(16'd7);
		send_sample(16'd8);
		send_sample(16'd9);
		s_tvalid <= 1'b0;
	endtask

	// corner, right edge and interior minima in one 3 x 5 frame
	task automatic test_edges_and_interior();
		logic [SAMPLE_IN_BITS-1:0] image [15] = '{
			16'd0, 16'd7,     16'd7, 16'd7, 16'd7,
			16'd7, 16'd7,     16'd1, 16'd7, 16'd3,
			16'd7, 16'hFFFF,  16'd7, 16'd7, 16'd7
		};
		int i;
		write_register(REG_NUM_ROWS, 13'd3);
		write_register(REG_NUM_COLS, 13'd5);
		for (i = 0; i < 15; i++) send_sample(image[i]);
		s_tvalid <= 1'b0;
	endtask

	// small random frames, some cut short by a register write
	task automatic test_random_frames();
		int length;
		int which;
		int f;
		bit cut_short;
		cut_short = 1'b1;
		for (f = 0; f < RANDOM_FRAMES; f++) begin
			if (cut_short || $urandom_range(0, 2) != 0) begin
				which = $urandom_range(0, 2);
				if (which != 1)
					write_register(REG_NUM_ROWS, CFG_DATA_BITS'($urandom_range(0, 6)));
				if (which != 0 || cut_short)
					write_register(REG_NUM_COLS, CFG_DATA_BITS'(
						($urandom_range(0, 63) << 7) | $urandom_range(0, 12)));
			end
			length = frame_rows() * frame_cols();
			cut_short = ($urandom_range(0, 4) == 0);
			if (cut_short) length = $urandom_range(1, length - 1);
			send_random_run(length);
		end
	endtask

	// full line depth while the receiver holds off and the input backs up
	task automatic test_wide_rows_under_backpressure();
		write_register(REG_NUM_ROWS, 13'd2);
		write_register(REG_NUM_COLS, 13'd127);
		stall_requests++;
		send_random_run(2 * LINE_DEPTH);
		// data bits above the register width drop out, leaving five columns
		write_register(REG_NUM_COLS, 13'h1F85);
		send_random_run(10);
	endtask

	// row count clamps to the limit; run without any idling on either side
	task automatic test_tall_frame();
		write_register(REG_NUM_COLS, 13'd2);
		write_register(REG_NUM_ROWS, 13'h1FFF);
		steady_flow = 1'b1;
		send_random_run(STEADY_SAMPLES);
		steady_flow = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_frame();
		test_register_clamp();
		test_edges_and_interior();
		test_random_frames();
		test_wide_rows_under_backpressure();
		test_tall_frame();
		wait_until_idle();
		if (mismatches == 0) begin
			$display("strict_local_minimum_detector_3x3_core regression: pass");
		end else begin
			$display("strict_local_minimum_detector_3x3_core regression: fail");
		end
		$finish;
	end

endmodule
